>>> design/crr_pkg.sv
// Shared types, constants and codes for the clock request resolver.
package crr_pkg;

	// Number of consumer slots and the index width that follows from it
	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int RANK_W = 32;

	// Clock node codes
	localparam logic [1:0] NODE_HF   = 2'd0;
	localparam logic [1:0] NODE_XO   = 2'd1;
	localparam logic [1:0] NODE_LF   = 2'd2;
	localparam logic [1:0] NODE_NONE = 2'd3;

	// Source codes
	localparam logic [1:0] SRC_INTERNAL = 2'd0;
	localparam logic [1:0] SRC_CRYSTAL  = 2'd1;
	localparam logic [1:0] SRC_ON       = 2'd1;

	// Item kind carried on tuser
	localparam logic FUNC_APPLY   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Leaf actions
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_REQUEST = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} crr_state_t;

	// One stored request
	typedef struct packed {
		logic [1:0]        node;
		logic [1:0]        source;
		logic [RANK_W-1:0] rank;
	} crr_slot_t;

	// One slot as read back during the walk
	typedef struct packed {
		logic      active;
		crr_slot_t slot;
	} crr_entry_t;

	// Running arbitration result
	typedef struct packed {
		logic [1:0] hf_src;
		logic [1:0] lf_src;
		logic       xo_on;
		logic       lf_on;
	} crr_arb_status_t;

endpackage

>>> design/crr_slot_table.sv
// Consumer slot table: request store with one write and one registered read port.
module crr_slot_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    rel_en,
	input  logic [crr_pkg::SLOT_W-1:0] waddr,
	input  crr_pkg::crr_slot_t      wdata,
	input  logic                    rd_en,
	input  logic [crr_pkg::SLOT_W-1:0] raddr,
	output crr_pkg::crr_entry_t     rdata
);
	import crr_pkg::*;

	logic [SLOTS-1:0] active_q;
	crr_slot_t        slot_mem_q [SLOTS];
	crr_entry_t       rdata_q;

	// Active bits clear at reset; the fields only matter once a slot is active
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (wr_en) begin
			active_q[waddr] <= 1'b1;
		end else if (rel_en) begin
			active_q[waddr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= '{active: active_q[raddr], slot: slot_mem_q[raddr]};
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/crr_arb.sv
// Shared rank comparator that folds one slot per cycle into the HF and LF winners.
module crr_arb (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     ent_vld,
	input  crr_pkg::crr_entry_t      ent,
	output crr_pkg::crr_arb_status_t status
);
	import crr_pkg::*;

	logic [RANK_W-1:0] hf_best_q;
	logic [RANK_W-1:0] lf_best_q;
	crr_arb_status_t   status_q;
	logic [RANK_W-1:0] best_sel;
	logic              lower;
	logic              take_hf;
	logic              take_lf;
	logic              xo_hit;

	// One comparator serves both muxes: the entry's node picks the running best
	assign best_sel = (ent.slot.node == NODE_HF) ? hf_best_q : lf_best_q;
	assign lower    = ent.slot.rank < best_sel;
	assign take_hf  = ent_vld && ent.active && (ent.slot.node == NODE_HF) && lower;
	assign take_lf  = ent_vld && ent.active && (ent.slot.node == NODE_LF) && lower;
	assign xo_hit   = ent_vld && ent.active && (ent.slot.node == NODE_XO)
		&& (ent.slot.source == SRC_ON);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hf_best_q <= '1;
			lf_best_q <= '1;
			status_q  <= '0;
		end else if (clear) begin
			hf_best_q <= '1;
			lf_best_q <= '1;
			status_q  <= '0;
		end else begin
			if (take_hf) begin
				hf_best_q       <= ent.slot.rank;
				status_q.hf_src <= ent.slot.source;
			end
			if (take_lf) begin
				lf_best_q       <= ent.slot.rank;
				status_q.lf_src <= ent.slot.source;
			end
			if (xo_hit) begin
				status_q.xo_on <= 1'b1;
			end
			// Any LF request counts, even one whose rank can never win
			if (ent_vld && ent.active && (ent.slot.node == NODE_LF)) begin
				status_q.lf_on <= 1'b1;
			end
		end
	end

	assign status = status_q;

`ifndef SYNTHESIS
	a_best_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!clear && !ent_vld |=> $stable(hf_best_q) && $stable(lf_best_q))
		else $error("arbitration best rank moved without an entry");
	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (hf_best_q == '1) && (lf_best_q == '1) && (status_q == '0))
		else $error("arbitration not restarted by clear");
	a_winner_is_lower: assert property (@(posedge clk) disable iff (!arst_n)
		take_hf |=> hf_best_q < $past(hf_best_q))
		else $error("HF winner rank not strictly lower");
`endif

endmodule

>>> design/clock_request_resolver.sv
// Clock request resolver top level: stream ports, walk sequencer and leaf tracking.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: func; tdata: slot, node, source, rank (40 bits)
//  m_axis    out        tdata: resolved tree and three leaf actions (16 bits)
//
// Each item goes from acceptance to a result in the output register in steps: the
// slot write lands on the accepting edge, then one table read per slot through the
// single read port and shared rank comparator, a drain step for the last read, and
// a resolve step that waits for the output register to be free. The next beat is
// taken in the idle state, so an item is not accepted while the last is in flight.
// The next item is taken as soon as the result is loaded, even while it still
// waits on m_axis_tready. arst_n clears all slots, the held leaf states and the
// output valid.
module clock_request_resolver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // consumer_slot[3:0], setting_node[5:4],
	                                   // setting_source[7:6], setting_rank[39:8]
	input  logic        s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // hf_uses_crystal[0], lf_source[2:1],
	                                   // xo24m_enabled[3], lf_enabled[4],
	                                   // crystal_enabled[5], crystal_action[7:6],
	                                   // xo24m_action[9:8], lf_action[11:10],
	                                   // zero[15:12]
);
	import crr_pkg::*;

	typedef struct packed {
		logic [3:0] pad;
		logic [1:0] lf_action;
		logic [1:0] xo24m_action;
		logic [1:0] crystal_action;
		logic       crystal_enabled;
		logic       lf_enabled;
		logic       xo24m_enabled;
		logic [1:0] lf_source;
		logic       hf_uses_crystal;
	} crr_result_t;

	crr_state_t      state_q;
	crr_state_t      state_nxt;
	logic [SLOT_W-1:0] cnt_q;
	logic            rd_vld_q;
	logic            crystal_held_q;
	logic            xo24m_held_q;
	logic            lf_held_q;
	logic            res_vld_q;
	crr_result_t     res_q;

	logic            in_acc;
	logic [31:0]     slot_ext;
	logic            in_range;
	logic            wr_en;
	logic            rel_en;
	crr_slot_t       wdata;
	logic            rd_en;
	logic            last_slot;
	logic            load_res;
	crr_entry_t      rdata;
	crr_arb_status_t status;
	logic            crystal_on;
	crr_result_t     res_nxt;

	function automatic logic [1:0] leaf_action(input logic held, input logic want);
		logic [1:0] act;
		act = ACT_NONE;
		if (want && !held) begin
			act = ACT_REQUEST;
		end else if (!want && held) begin
			act = ACT_RELEASE;
		end
		return act;
	endfunction

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign slot_ext  = {28'd0, s_axis_tdata[3:0]};
	assign in_range  = slot_ext < 32'(SLOTS);
	assign wr_en     = in_acc && in_range && (s_axis_tuser == FUNC_APPLY);
	assign rel_en    = in_acc && in_range && (s_axis_tuser == FUNC_RELEASE);
	assign wdata     = '{node: s_axis_tdata[5:4], source: s_axis_tdata[7:6],
		rank: s_axis_tdata[39:8]};
	assign last_slot = cnt_q == SLOT_W'(SLOTS - 1);

	crr_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.rel_en (rel_en),
		.waddr  (slot_ext[SLOT_W-1:0]),
		.wdata  (wdata),
		.rd_en  (rd_en),
		.raddr  (cnt_q),
		.rdata  (rdata)
	);

	crr_arb u_arb (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (in_acc),
		.ent_vld (rd_vld_q),
		.ent     (rdata),
		.status  (status)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (last_slot) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!res_vld_q || m_axis_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		load_res      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_WALK: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				load_res = !res_vld_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	// Upgrade HF to the crystal whenever the crystal runs
	assign crystal_on = (status.hf_src == SRC_CRYSTAL) || status.xo_on;

	always_comb begin
		res_nxt                 = '0;
		res_nxt.hf_uses_crystal = crystal_on;
		res_nxt.lf_source       = status.lf_src;
		res_nxt.xo24m_enabled   = status.xo_on;
		res_nxt.lf_enabled      = status.lf_on;
		res_nxt.crystal_enabled = crystal_on;
		res_nxt.crystal_action  = leaf_action(crystal_held_q, crystal_on);
		res_nxt.xo24m_action    = leaf_action(xo24m_held_q, status.xo_on);
		res_nxt.lf_action       = leaf_action(lf_held_q, status.lf_on);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			rd_vld_q       <= 1'b0;
			crystal_held_q <= 1'b0;
			xo24m_held_q   <= 1'b0;
			lf_held_q      <= 1'b0;
			res_vld_q      <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			rd_vld_q <= rd_en;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (rd_en && !last_slot) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_res) begin
				crystal_held_q <= crystal_on;
				xo24m_held_q   <= status.xo_on;
				lf_held_q      <= status.lf_on;
				res_vld_q      <= 1'b1;
			end else if (m_axis_tready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = res_q;

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the resolve step");
	a_held_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> (crystal_held_q == res_q.crystal_enabled)
			&& (xo24m_held_q == res_q.xo24m_enabled)
			&& (lf_held_q == res_q.lf_enabled))
		else $error("held leaf state disagrees with the pending result");
	a_xo_needs_crystal: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.xo24m_enabled |-> res_q.crystal_enabled
			&& res_q.hf_uses_crystal)
		else $error("24 MHz clock on without the crystal");
	a_walk_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q == ST_WALK) && $past(last_slot))
		else $error("walk left before the last slot");
`endif

endmodule

>>> test/clock_request_resolver_check.sv
`timescale 1ns / 100ps
// Scoreboard for the clock request resolver: predicts each resolved tree and checks output beats.
module clock_request_resolver_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // consumer_slot[3:0], setting_node[5:4],
	                                   // setting_source[7:6], setting_rank[39:8]
	input  logic        s_axis_tuser,  // func[0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // hf_uses_crystal[0], lf_source[2:1],
	                                   // xo24m_enabled[3], lf_enabled[4],
	                                   // crystal_enabled[5], crystal_action[7:6],
	                                   // xo24m_action[9:8], lf_action[11:10]
	output int          fail_count,
	output int          trees_owed
);
	import crr_pkg::*;

	typedef struct packed {
		logic       hf_xtal;
		logic [1:0] lf_src;
		logic       xo_on;
		logic       lf_on;
		logic       xtal_on;
		logic [1:0] xtal_act;
		logic [1:0] xo_act;
		logic [1:0] lf_act;
	} tree_t;

	// Own copy of the request table and the held leaf states
	logic              slot_busy   [SLOTS];
	logic [1:0]        slot_node   [SLOTS];
	logic [1:0]        slot_source [SLOTS];
	logic [RANK_W-1:0] slot_rank   [SLOTS];
	logic              xtal_held;
	logic              xo_held;
	logic              lf_held;

	tree_t pending_trees[$];

	function automatic logic [1:0] leaf_move(input logic held, input logic want);
		if (want && !held)
			return ACT_REQUEST;
		if (!want && held)
			return ACT_RELEASE;
		return ACT_NONE;
	endfunction

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Update the table with one item, walk it and queue the resolved tree
	task automatic resolve_tree(input logic func, input logic [3:0] slot, input logic [1:0] node,
			input logic [1:0] src, input logic [RANK_W-1:0] rank);
		logic              hf_seen;
		logic              xo_want;
		logic              lf_want;
		logic              xtal_want;
		logic [RANK_W-1:0] hf_low;
		logic [RANK_W-1:0] lf_low;
		logic [1:0]        hf_pick;
		logic [1:0]        lf_pick;
		tree_t             t;
		if (int'(slot) < SLOTS) begin
			if (func == FUNC_APPLY) begin
				slot_busy[slot]   = 1'b1;
				slot_node[slot]   = node;
				slot_source[slot] = src;
				slot_rank[slot]   = rank;
			end else begin
				slot_busy[slot] = 1'b0;
			end
		end
		hf_seen = 1'b0;
		xo_want = 1'b0;
		lf_want = 1'b0;
		hf_low  = '1;
		lf_low  = '1;
		hf_pick = SRC_INTERNAL;
		lf_pick = SRC_INTERNAL;
		// strictly lower rank wins, so the earlier slot keeps a tie
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i]) begin
				case (slot_node[i])
					NODE_HF: begin
						hf_seen = 1'b1;
						if (slot_rank[i] < hf_low) begin
							hf_low  = slot_rank[i];
							hf_pick = slot_source[i];
						end
					end
					NODE_XO: begin
						if (slot_source[i] == SRC_ON)
							xo_want = 1'b1;
					end
					NODE_LF: begin
						lf_want = 1'b1;
						if (slot_rank[i] < lf_low) begin
							lf_low  = slot_rank[i];
							lf_pick = slot_source[i];
						end
					end
					default: begin
					end
				endcase
			end
		end
		xtal_want  = (hf_seen && hf_pick == SRC_CRYSTAL) || xo_want;
		t.hf_xtal  = xtal_want;
		t.lf_src   = lf_pick;
		t.xo_on    = xo_want;
		t.lf_on    = lf_want;
		t.xtal_on  = xtal_want;
		t.xtal_act = leaf_move(xtal_held, xtal_want);
		t.xo_act   = leaf_move(xo_held, xo_want);
		t.lf_act   = leaf_move(lf_held, lf_want);
		xtal_held  = xtal_want;
		xo_held    = xo_want;
		lf_held    = lf_want;
		pending_trees.push_back(t);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tree_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i]   = 1'b0;
				slot_node[i]   = NODE_HF;
				slot_source[i] = SRC_INTERNAL;
				slot_rank[i]   = '0;
			end
			xtal_held = 1'b0;
			xo_held   = 1'b0;
			lf_held   = 1'b0;
			pending_trees.delete();
			trees_owed = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_trees.size() == 0) begin
					$error("result beat %h with no tree expected", m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_trees.pop_front();
					check_field("hf_uses_crystal", {1'b0, want.hf_xtal},
						{1'b0, m_axis_tdata[0]});
					check_field("lf_source", want.lf_src, m_axis_tdata[2:1]);
					check_field("xo24m_enabled", {1'b0, want.xo_on}, {1'b0, m_axis_tdata[3]});
					check_field("lf_enabled", {1'b0, want.lf_on}, {1'b0, m_axis_tdata[4]});
					check_field("crystal_enabled", {1'b0, want.xtal_on},
						{1'b0, m_axis_tdata[5]});
					check_field("crystal_action", want.xtal_act, m_axis_tdata[7:6]);
					check_field("xo24m_action", want.xo_act, m_axis_tdata[9:8]);
					check_field("lf_action", want.lf_act, m_axis_tdata[11:10]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				resolve_tree(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[5:4],
					s_axis_tdata[7:6], s_axis_tdata[39:8]);
			trees_owed = pending_trees.size();
		end
	end

endmodule

>>> test/clock_request_resolver_test.sv
`timescale 1ns / 100ps
// Testbench top for the clock request resolver: clock, reset, request stimulus and verdict.
module clock_request_resolver_test;
	import crr_pkg::*;

	// Source codes with no name of their own in the package
	localparam logic [1:0] SRC_SPARE2 = 2'd2;
	localparam logic [1:0] SRC_SPARE3 = 2'd3;
	localparam logic [31:0] RANK_TOP  = 32'hFFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // consumer_slot[3:0], setting_node[5:4],
	                            // setting_source[7:6], setting_rank[39:8]
	logic        s_axis_tuser;  // func[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // hf_uses_crystal[0], lf_source[2:1], xo24m_enabled[3],
	                            // lf_enabled[4], crystal_enabled[5], crystal_action[7:6],
	                            // xo24m_action[9:8], lf_action[11:10]

	int   fail_count;
	int   trees_owed;
	int   send_gap_pct = 23;
	int   take_gap_pct = 49;
	logic stall_now    = 1'b0;
	logic s_taken      = 1'b0;

	always #1 clk = ~clk;

	clock_request_resolver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	clock_request_resolver_check tree_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.trees_owed    (trees_owed)
	);

	// Note each input beat at the edge so the sender can see it at the next falling edge
	always @(posedge clk) begin
		s_taken <= s_axis_tvalid && s_axis_tready;
	end

	task automatic send_item(input logic func, input logic [3:0] slot, input logic [1:0] node,
			input logic [1:0] src, input logic [31:0] rank);
		if ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {rank, src, node, slot};
		do @(negedge clk); while (!s_taken);
	endtask

	task automatic send_random();
		logic        func;
		logic [1:0]  node;
		logic [1:0]  src;
		logic [31:0] rank;
		logic [3:0]  slot;
		int          pick;
		func = ($urandom_range(99) < 35) ? FUNC_RELEASE : FUNC_APPLY;
		slot = 4'($urandom_range(15));
		pick = $urandom_range(9);
		node = (pick < 4) ? NODE_HF : (pick < 6) ? NODE_XO : (pick < 9) ? NODE_LF : NODE_NONE;
		// lean towards the two meaningful sources
		if ($urandom_range(1))
			src = 2'($urandom_range(3));
		else
			src = 2'($urandom_range(1));
		// small ranks make ties common
		case ($urandom_range(7))
			0:       rank = '0;
			1:       rank = RANK_TOP;
			2, 3, 4: rank = $urandom_range(7);
			default: rank = $urandom;
		endcase
		send_item(func, slot, node, src, rank);
	endtask

	// Receiver: random ready, with a long hold-off whenever one is asked for
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_now) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
				stall_now = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_APPLY;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// crystal on HF, then a tie that the earlier slot keeps, then back to internal
		send_item(FUNC_APPLY, 4'd0, NODE_HF, SRC_CRYSTAL, 32'd0);
		send_item(FUNC_APPLY, 4'd1, NODE_HF, SRC_INTERNAL, 32'd0);
		send_item(FUNC_APPLY, 4'd0, NODE_HF, SRC_INTERNAL, 32'd0);
		// XO24M only turns on with source on, and drags the crystal with it
		send_item(FUNC_APPLY, 4'd2, NODE_XO, SRC_SPARE2, RANK_TOP);
		send_item(FUNC_APPLY, 4'd3, NODE_XO, SRC_ON, 32'd9);
		send_item(FUNC_RELEASE, 4'd3, NODE_XO, SRC_ON, 32'd9);
		// LF: top rank never wins but still enables; ties and a lower rank
		send_item(FUNC_APPLY, 4'd4, NODE_LF, SRC_SPARE3, RANK_TOP);
		send_item(FUNC_APPLY, 4'd5, NODE_LF, SRC_SPARE2, 32'd5);
		send_item(FUNC_APPLY, 4'd6, NODE_LF, SRC_CRYSTAL, 32'd5);
		send_item(FUNC_APPLY, 4'd7, NODE_LF, SRC_SPARE3, 32'd4);
		// HF request at top rank cannot win
		send_item(FUNC_APPLY, 4'd15, NODE_HF, SRC_CRYSTAL, RANK_TOP);
		send_item(FUNC_RELEASE, 4'd0, NODE_HF, SRC_INTERNAL, 32'd0);
		send_item(FUNC_RELEASE, 4'd1, NODE_HF, SRC_INTERNAL, 32'd0);
		// other HF sources mean internal
		send_item(FUNC_APPLY, 4'd14, NODE_HF, SRC_SPARE3, 32'd1);
		send_item(FUNC_APPLY, 4'd13, NODE_HF, SRC_CRYSTAL, 32'hFFFF_FFFE);
		send_item(FUNC_APPLY, 4'd12, NODE_HF, SRC_SPARE2, 32'd0);
		// ignored node takes no part, even with node, source and rank at their top
		send_item(FUNC_APPLY, 4'd9, NODE_NONE, SRC_CRYSTAL, 32'd0);
		send_item(FUNC_APPLY, 4'd9, NODE_NONE, SRC_SPARE3, RANK_TOP);
		// release of an empty slot, then of the ignored one
		send_item(FUNC_RELEASE, 4'd8, NODE_NONE, SRC_SPARE3, RANK_TOP);
		send_item(FUNC_RELEASE, 4'd9, NODE_HF, SRC_INTERNAL, 32'd0);
		// overwrite an XO24M slot with an HF crystal request
		send_item(FUNC_APPLY, 4'd10, NODE_XO, SRC_ON, 32'd0);
		send_item(FUNC_APPLY, 4'd10, NODE_HF, SRC_CRYSTAL, 32'd0);
		send_item(FUNC_RELEASE, 4'd10, NODE_HF, SRC_CRYSTAL, 32'd0);

		stall_now = 1'b1;
		repeat (550) send_random();
		send_gap_pct = 49;
		take_gap_pct = 23;
		repeat (550) send_random();
		send_gap_pct = 0;
		take_gap_pct = 0;
		stall_now    = 1'b1;
		repeat (530) send_random();
		s_axis_tvalid <= 1'b0;

		while (trees_owed != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
design/crr_pkg.sv
design/crr_slot_table.sv
design/crr_arb.sv
design/clock_request_resolver.sv
test/clock_request_resolver_check.sv
test/clock_request_resolver_test.sv
